FILE: rtl/demand_pacing_controller_top_defines.svh
// ----------------------------------------------------------------------------
// Demand pacing controller assertion macros
// Shared assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef DEMAND_PACING_CONTROLLER_TOP_DEFINES_SVH
`define DEMAND_PACING_CONTROLLER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define DPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define DPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPC_ASSERT(lbl, prop, msg)
`define DPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/dpc_pkg.sv
// ----------------------------------------------------------------------------
// Demand pacing controller package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Moving-average window length, 1 to 16.
  localparam int WINDOW_LEN = 5;

  // The window sum and its magnitude fit in SUM_W bits.
  localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW_LEN);
  // Exact floor division by WINDOW_LEN for magnitudes below 2**SUM_W:
  // multiply by ceil(2**DIV_SHIFT / WINDOW_LEN) and shift right.
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  // Queue between the front and back halves.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SENSE_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_BAND      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_PACING_INTERVAL = CFG_IDX_W'(3);

  // Register reset values.
  localparam logic signed [CFG_DATA_W-1:0] RST_SENSE_THRESHOLD = 16'sd1500;
  localparam logic [CFG_DATA_W-1:0]        RST_NOISE_BAND      = 16'd50;
  localparam logic [CFG_DATA_W-1:0]        RST_REFRACTORY      = 16'd250;
  localparam logic [CFG_DATA_W-1:0]        RST_PACING_INTERVAL = 16'd1000;

  typedef enum logic [1:0] {
    ST_PACED    = 2'd0,
    ST_PENDING  = 2'd1,
    ST_ABNORMAL = 2'd2,
    ST_NORMAL   = 2'd3
  } dpc_status_t;

  typedef struct packed {
    logic signed [CFG_DATA_W-1:0] sense_threshold_uv;
    logic [CFG_DATA_W-1:0]        noise_band_uv;
    logic [CFG_DATA_W-1:0]        refractory_ms;
    logic [CFG_DATA_W-1:0]        pacing_interval_ms;
  } dpc_cfg_t;

  // Classified word handed from the front half to the back half.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed_uv;
    logic [TIME_W-1:0]          time_ms;
    logic                       below;
    logic                       abnormal;
  } dpc_entry_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed_uv;
    logic                       pace;
    dpc_status_t                status;
    logic                       in_refractory;
  } dpc_result_t;

endpackage

FILE: rtl/dpc_ifs.sv
// ----------------------------------------------------------------------------
// Demand pacing controller channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dpc_in_if import dpc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_uv;
  logic [TIME_W-1:0]          time_ms;

  modport source (output valid, output sample_uv, output time_ms, input ready);
  modport sink   (input valid, input sample_uv, input time_ms, output ready);
endinterface

interface dpc_out_if import dpc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] smoothed_uv;
  logic                       pace;
  dpc_status_t                status;
  logic                       in_refractory;

  modport source (output valid, output smoothed_uv, output pace, output status,
                  output in_refractory, input ready);
  modport sink   (input valid, input smoothed_uv, input pace, input status,
                  input in_refractory, output ready);
endinterface

interface dpc_cfg_if import dpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/dpc_front.sv
// ----------------------------------------------------------------------------
// Demand pacing controller front half
// Takes samples, keeps the moving-average window and classifies the average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "demand_pacing_controller_top_defines.svh"

module dpc_front import dpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dpc_cfg_t   cfg,
  dpc_in_if.sink     in_ch,
  output logic       push_valid,
  output dpc_entry_t push_data,
  input  logic       push_ready
);

  logic signed [SAMPLE_W-1:0] window_r [WINDOW_LEN];
  // The running window sum doubles as the first stage's payload.
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic                       a_valid_r;
  logic [TIME_W-1:0]          a_time_r;

  logic                       b_valid_r;
  logic [SAMPLE_W-1:0]        quot_r;
  logic                       neg_r;
  logic [TIME_W-1:0]          b_time_r;

  logic                       accept;
  logic                       a_load;
  logic                       b_load;
  logic [SUM_W-1:0]           mag;
  logic [PROD_W-1:0]          prod;
  logic signed [SAMPLE_W-1:0] avg;
  logic signed [SAMPLE_W:0]   dev;
  logic [SAMPLE_W:0]          abs_dev;

  assign b_load      = !b_valid_r || push_ready;
  assign a_load      = !a_valid_r || b_load;
  assign in_ch.ready = a_load;
  assign accept      = in_ch.valid && a_load;

  assign sum_nxt = sum_r + SUM_W'(in_ch.sample_uv) - SUM_W'(window_r[WINDOW_LEN-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (accept) begin
      window_r[0] <= in_ch.sample_uv;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        window_r[i] <= window_r[i-1];
      end
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_r <= in_ch.valid;
      end
      if (b_load) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  // Divide the magnitude by the window length, then restore the sign so the
  // quotient truncates toward zero.
  assign mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign prod = PROD_W'(mag) * PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (accept) begin
      a_time_r <= in_ch.time_ms;
    end
    if (b_load && a_valid_r) begin
      quot_r   <= prod[DIV_SHIFT +: SAMPLE_W];
      neg_r    <= sum_r[SUM_W-1];
      b_time_r <= a_time_r;
    end
  end

  assign avg     = neg_r ? SAMPLE_W'(-quot_r) : SAMPLE_W'(quot_r);
  assign dev     = (SAMPLE_W+1)'(avg) - (SAMPLE_W+1)'(cfg.sense_threshold_uv);
  assign abs_dev = dev[SAMPLE_W] ? (SAMPLE_W+1)'(-dev) : (SAMPLE_W+1)'(dev);

  assign push_valid            = b_valid_r;
  assign push_data.smoothed_uv = avg;
  assign push_data.time_ms     = b_time_r;
  assign push_data.below       = avg < cfg.sense_threshold_uv;
  assign push_data.abnormal    = abs_dev > {1'b0, cfg.noise_band_uv};

  `DPC_ASSERT(a_front_stall_holds_sum, a_valid_r && !b_load |=> a_valid_r && $stable(sum_r), "window sum changed while the first stage was stalled")

endmodule

FILE: rtl/dpc_queue.sv
// ----------------------------------------------------------------------------
// Demand pacing controller queue
// Short register queue that decouples the front and back halves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "demand_pacing_controller_top_defines.svh"

module dpc_queue import dpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  dpc_entry_t push_data,
  output logic       push_ready,
  output logic       pop_valid,
  output dpc_entry_t pop_data,
  input  logic       pop_ready
);

  dpc_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               push;
  logic               pop;

  assign push_ready = count_r != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `DPC_ASSERT(a_queue_count_bound, count_r <= Q_CNT_W'(Q_DEPTH), "queue count exceeds its depth")
  `DPC_ASSERT(a_queue_empty_ptrs, count_r == '0 |-> wr_ptr_r == rd_ptr_r, "empty queue with pointers apart")

endmodule

FILE: rtl/dpc_back.sv
// ----------------------------------------------------------------------------
// Demand pacing controller back half
// Tracks refractory and pacing timing and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "demand_pacing_controller_top_defines.svh"

module dpc_back import dpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dpc_cfg_t   cfg,
  input  logic       pop_valid,
  input  dpc_entry_t pop_data,
  output logic       pop_ready,
  dpc_out_if.source  out_ch
);

  logic [TIME_W-1:0] last_pace_r;
  logic              refr_r, refr_nxt;
  logic              out_valid_r;
  dpc_result_t       out_r;
  dpc_result_t       res;

  logic              pop;
  logic [TIME_W-1:0] elapsed;
  logic              refr_hold;
  logic              pace_now;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  // Elapsed time wraps modulo 2**32, so an earlier stamp reads as a long wait.
  assign elapsed   = pop_data.time_ms - last_pace_r;
  assign refr_hold = refr_r && (elapsed < TIME_W'(cfg.refractory_ms));

  always_comb begin
    pace_now          = 1'b0;
    refr_nxt          = refr_hold;
    res.smoothed_uv   = pop_data.smoothed_uv;
    res.status        = pop_data.abnormal ? ST_ABNORMAL : ST_NORMAL;
    if (pop_data.below && !refr_hold) begin
      if (elapsed >= TIME_W'(cfg.pacing_interval_ms)) begin
        pace_now   = 1'b1;
        refr_nxt   = 1'b1;
        res.status = ST_PACED;
      end else begin
        res.status = ST_PENDING;
      end
    end
    res.pace          = pace_now;
    res.in_refractory = refr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pace_r <= '0;
      refr_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        refr_r <= refr_nxt;
        if (pace_now) begin
          last_pace_r <= pop_data.time_ms;
        end
      end
      if (pop_ready) begin
        out_valid_r <= pop_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.smoothed_uv   = out_r.smoothed_uv;
  assign out_ch.pace          = out_r.pace;
  assign out_ch.status        = out_r.status;
  assign out_ch.in_refractory = out_r.in_refractory;

  `DPC_ASSERT(a_pace_is_consistent, out_valid_r && out_r.pace |-> out_r.in_refractory && out_r.status == ST_PACED, "pace without paced status or refractory flag")
  `DPC_ASSERT(a_pace_records_time, pop && pace_now |=> last_pace_r == $past(pop_data.time_ms), "pace did not record its own timestamp")
  `DPC_ASSERT_ALWAYS(a_reset_clears_result, !rst_n |=> !out_valid_r, "result valid right after reset")

endmodule

FILE: rtl/demand_pacing_controller_top.sv
// ----------------------------------------------------------------------------
// Demand pacing controller top level
// VVI-style demand pacing timing on a stream of sensed samples.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock and returns one result word per
// sample in order, sustaining one word per cycle while the result side keeps
// up. A sample passes in order through the running window sum register, the
// quotient register loaded by the reciprocal multiply that divides the sum by
// the window length, the queue, and the result register, where the refractory
// and pacing timers update for each word. Register writes are taken at once
// and belong only in idle periods.
`timescale 1ns / 1ps

module demand_pacing_controller_top import dpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dpc_cfg_if.sink   cfg_ch,
  dpc_in_if.sink    in_ch,
  dpc_out_if.source out_ch
);

  dpc_cfg_t   cfg_r;
  logic       push_valid;
  logic       push_ready;
  dpc_entry_t push_data;
  logic       pop_valid;
  logic       pop_ready;
  dpc_entry_t pop_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sense_threshold_uv <= RST_SENSE_THRESHOLD;
      cfg_r.noise_band_uv      <= RST_NOISE_BAND;
      cfg_r.refractory_ms      <= RST_REFRACTORY;
      cfg_r.pacing_interval_ms <= RST_PACING_INTERVAL;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SENSE_THRESHOLD: cfg_r.sense_threshold_uv <= cfg_ch.data;
        CFG_NOISE_BAND:      cfg_r.noise_band_uv      <= cfg_ch.data;
        CFG_REFRACTORY:      cfg_r.refractory_ms      <= cfg_ch.data;
        CFG_PACING_INTERVAL: cfg_r.pacing_interval_ms <= cfg_ch.data;
        default: begin
          // Writes to unknown indexes are dropped.
        end
      endcase
    end
  end

  dpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  dpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  dpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/dpc_pacing_checker.sv
// ----------------------------------------------------------------------------
// Demand pacing controller result checker
// Watches the register, sample and result channels, keeps its own copy of
// the window, pace timing and registers, and compares every result word
// with the prediction made when its sample word was accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpc_pacing_checker import dpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  dpc_cfg_if   cfg_ch,
  dpc_in_if    in_ch,
  dpc_out_if   out_ch,
  output int   mismatch_count,
  output int   outstanding,
  output int   checked_count,
  output int   paced_count
);

  // Register copy.
  logic signed [CFG_DATA_W-1:0] thr_uv;
  logic [CFG_DATA_W-1:0]        band_uv;
  logic [CFG_DATA_W-1:0]        refr_ms;
  logic [CFG_DATA_W-1:0]        interval_ms;

  // Pacing state copy.
  logic signed [SAMPLE_W-1:0] window_q [WINDOW_LEN];
  logic [TIME_W-1:0]          last_pace_ms;
  logic                       refractory_on;

  dpc_result_t result_backlog [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    checked_count  = 0;
    paced_count    = 0;
  end

  // Shifts one sample in and works out the pacing decision for it.
  task automatic pace_decision(input logic signed [SAMPLE_W-1:0] sample,
                               input logic [TIME_W-1:0] now,
                               output dpc_result_t res);
    int                sum;
    int                avg;
    int                dev;
    logic [TIME_W-1:0] elapsed;
    for (int i = WINDOW_LEN - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = sample;
    sum = 0;
    for (int i = 0; i < WINDOW_LEN; i++) sum += window_q[i];
    // Integer division truncates toward zero, as the block does.
    avg = sum / WINDOW_LEN;

    // Elapsed time wraps, so an earlier timestamp reads as a long wait.
    elapsed = now - last_pace_ms;
    if (refractory_on && elapsed >= TIME_W'(refr_ms)) refractory_on = 1'b0;

    res.smoothed_uv = avg[SAMPLE_W-1:0];
    res.pace        = 1'b0;
    if (avg < int'(thr_uv) && !refractory_on) begin
      if (elapsed >= TIME_W'(interval_ms)) begin
        last_pace_ms  = now;
        refractory_on = 1'b1;
        res.pace      = 1'b1;
        res.status    = ST_PACED;
      end else begin
        res.status = ST_PENDING;
      end
    end else begin
      dev = avg - int'(thr_uv);
      if (dev < 0) dev = -dev;
      if (dev > int'(band_uv)) begin
        res.status = ST_ABNORMAL;
      end else begin
        res.status = ST_NORMAL;
      end
    end
    res.in_refractory = refractory_on;
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : monitor
    dpc_result_t want;
    if (!rst_n) begin
      thr_uv        = RST_SENSE_THRESHOLD;
      band_uv       = RST_NOISE_BAND;
      refr_ms       = RST_REFRACTORY;
      interval_ms   = RST_PACING_INTERVAL;
      for (int i = 0; i < WINDOW_LEN; i++) window_q[i] = '0;
      last_pace_ms  = '0;
      refractory_on = 1'b0;
      result_backlog.delete();
    end else begin
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        case (cfg_ch.index)
          CFG_SENSE_THRESHOLD: thr_uv      = signed'(cfg_ch.data);
          CFG_NOISE_BAND:      band_uv     = cfg_ch.data;
          CFG_REFRACTORY:      refr_ms     = cfg_ch.data;
          CFG_PACING_INTERVAL: interval_ms = cfg_ch.data;
          default: ;
        endcase
      end

      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (result_backlog.size() == 0) begin
          report_mismatch($sformatf(
            "unexpected word: smoothed=%0d pace=%0b status=%0d refr=%0b",
            $signed(out_ch.smoothed_uv), out_ch.pace, out_ch.status,
            out_ch.in_refractory));
        end else begin
          want = result_backlog.pop_front();
          checked_count++;
          if (out_ch.pace === 1'b1) paced_count++;
          if (out_ch.smoothed_uv !== want.smoothed_uv || out_ch.pace !== want.pace ||
              out_ch.status !== want.status ||
              out_ch.in_refractory !== want.in_refractory) begin
            report_mismatch($sformatf(
              "word %0d: expected smoothed=%0d pace=%0b status=%0d refr=%0b, %s",
              checked_count, $signed(want.smoothed_uv), want.pace, want.status,
              want.in_refractory,
              $sformatf("got smoothed=%0d pace=%0b status=%0d refr=%0b",
                        $signed(out_ch.smoothed_uv), out_ch.pace, out_ch.status,
                        out_ch.in_refractory)));
          end
        end
      end

      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        pace_decision(in_ch.sample_uv, in_ch.time_ms, want);
        result_backlog.push_back(want);
      end
    end
    outstanding = result_backlog.size();
  end

endmodule

FILE: tb/tb_demand_pacing_controller_top.sv
// ----------------------------------------------------------------------------
// Demand pacing controller testbench
// Drives timed samples through several register settings, with random gaps
// and stalls on both channels, and takes its verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_demand_pacing_controller_top;
  import dpc_pkg::*;

  localparam int PIPE_DRAIN = 8;
  localparam int LONG_HOLD  = 80;

  bit   clk;
  logic rst_n;

  int mismatch_count;
  int outstanding;
  int checked_count;
  int paced_count;
  int setting_count;

  bit hold_req;
  bit free_run;

  // Stimulus shaping: where the samples cluster and how fast time moves.
  int                thr_level;
  int                band_level;
  int                time_step_max;
  logic [TIME_W-1:0] clock_ms;

  dpc_cfg_if cfg_ch ();
  dpc_in_if  in_ch ();
  dpc_out_if out_ch ();

  demand_pacing_controller_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dpc_pacing_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_ch         (cfg_ch),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .checked_count  (checked_count),
    .paced_count    (paced_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: mostly short runs of ready and stall, now and then a long
  // stall, and a long hold-off whenever one is requested so the block backs up.
  initial begin : result_sink
    int run_len;
    int pick;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      pick = $urandom_range(0, 99);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        run_len  = LONG_HOLD;
        hold_req = 1'b0;
      end else if (free_run || pick < 60) begin
        out_ch.ready <= 1'b1;
        run_len = $urandom_range(1, 8);
      end else if (pick < 94) begin
        out_ch.ready <= 1'b0;
        run_len = $urandom_range(1, 3);
      end else begin
        out_ch.ready <= 1'b0;
        run_len = $urandom_range(10, 30);
      end
      repeat (run_len - 1) @(negedge clk);
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample,
                             input logic [TIME_W-1:0] stamp);
    in_ch.valid     <= 1'b1;
    in_ch.sample_uv <= sample;
    in_ch.time_ms   <= stamp;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (free_run || pick < 70) return;
    in_ch.valid <= 1'b0;
    if (pick < 95) begin
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end else begin
      repeat ($urandom_range(8, 30)) @(negedge clk);
    end
  endtask

  // Waits until every expected word has come back and the pipe is empty.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input int thr, input int band, input int refr,
                               input int interval);
    drain_results();
    write_reg(CFG_SENSE_THRESHOLD, thr);
    write_reg(CFG_NOISE_BAND, band);
    write_reg(CFG_REFRACTORY, refr);
    write_reg(CFG_PACING_INTERVAL, interval);
    thr_level  = thr;
    band_level = band;
    setting_count++;
  endtask

  // Most samples sit around the threshold so that pacing, waiting and both
  // band classes all come up; the rest are full-range or at the rails.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int pick;
    int span;
    int v;
    pick = $urandom_range(0, 99);
    span = band_level + 400;
    if (pick < 70) begin
      v = thr_level + int'($urandom_range(0, 2 * span)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return SAMPLE_W'(v);
    end else if (pick < 92) begin
      return SAMPLE_W'($urandom);
    end else if (pick < 96) begin
      return 16'sh7fff;
    end else begin
      return 16'sh8000;
    end
  endfunction

  // Time mostly moves forward; a few jumps land anywhere, backward too.
  function automatic logic [TIME_W-1:0] next_time();
    if ($urandom_range(0, 99) < 4) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, time_step_max);
    end
    return clock_ms;
  endfunction

  task automatic run_samples(input int count);
    for (int i = 0; i < count; i++) begin
      sender_gap();
      send_sample(pick_sample(), next_time());
    end
  endtask

  initial begin : stimulus
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.sample_uv  = '0;
    in_ch.time_ms    = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    hold_req         = 1'b0;
    free_run         = 1'b0;
    setting_count    = 1;
    thr_level        = 1500;
    band_level       = 50;
    time_step_max    = 300;
    clock_ms         = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Interval and refractory edges under the reset settings.
    send_sample(0, 0);
    send_sample(0, 999);
    send_sample(0, 1000);
    // Low while still refractory: classed by the band instead of pacing.
    send_sample(0, 1100);
    send_sample(0, 1250);
    send_sample(0, 2250);
    // A timestamp earlier than the last pace reads as a very long wait.
    send_sample(0, 2000);
    send_sample(0, 32'hffff_ffff);
    send_sample(0, 32'h0000_0100);
    // Steady level exactly one band above the threshold, then one more.
    clock_ms = 32'h0000_0200;
    repeat (5) send_sample(1550, next_time());
    send_sample(1555, next_time());
    repeat (3) send_sample(16'sh7fff, next_time());
    repeat (3) send_sample(16'sh8000, next_time());
    send_sample(-1, next_time());

    run_samples(200);

    // Nothing can be below the lowest threshold; all timers at zero.
    apply_setting(-32768, 0, 0, 0);
    // Writes to unused register indexes must be ignored.
    write_reg(CFG_IDX_W'(4), $urandom);
    write_reg(CFG_IDX_W'(255), $urandom);
    time_step_max = 50;
    run_samples(150);

    // Everything but a window full of the top rail is low, and the timers are as long as they get.
    apply_setting(32767, 65535, 65535, 65535);
    time_step_max = 3000;
    hold_req = 1'b1;
    run_samples(150);

    // Zero threshold and zero timers, both sides running flat out.
    apply_setting(0, 0, 0, 0);
    time_step_max = 20;
    free_run = 1'b1;
    run_samples(150);
    free_run = 1'b0;

    for (int p = 0; p < 5; p++) begin
      apply_setting(int'($urandom_range(0, 6000)) - 3000, $urandom_range(0, 300),
                    $urandom_range(0, 600), $urandom_range(0, 1500));
      time_step_max = $urandom_range(20, 300);
      if (p == 2) hold_req = 1'b1;
      run_samples(150);
    end

    drain_results();
    $display("Checked %0d result words, %0d of them paces, over %0d register settings.",
             checked_count, paced_count, setting_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dpc_pkg.sv
rtl/dpc_ifs.sv
rtl/dpc_front.sv
rtl/dpc_queue.sv
rtl/dpc_back.sv
rtl/demand_pacing_controller_top.sv
tb/dpc_pacing_checker.sv
tb/tb_demand_pacing_controller_top.sv
